// ===== design/tsi_pkg.sv =====
package tsi_pkg;

    localparam int POS_BITS   = 24;
    localparam int DELAY_BITS = 20;
    localparam int MAG_W      = POS_BITS + 1;
    localparam int JOG_CNT_W  = 16;
    localparam int SCALE_W    = 6;
    localparam int JOG_AMT_W  = JOG_CNT_W + SCALE_W;
    localparam int SUM_W      = ((POS_BITS > JOG_AMT_W) ? POS_BITS : JOG_AMT_W) + 2;
    localparam int NUM_AXES   = 3;

    localparam logic [SCALE_W-1:0] JOG_SCALE_RESET = SCALE_W'(8);

    localparam logic signed [SUM_W-1:0] SUM_POS_MAX = SUM_W'((64'd1 << (POS_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SUM_POS_MIN = ~SUM_POS_MAX;
    localparam logic signed [SUM_W-1:0] SUM_ONE     = SUM_W'(1);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        OP_MOVE = 2'd0,
        OP_TICK = 2'd1,
        OP_ZERO = 2'd2,
        OP_JOG  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [POS_BITS-1:0]    target_x;
        logic signed [POS_BITS-1:0]    target_y;
        logic signed [POS_BITS-1:0]    target_z;
        logic                          move_x;
        logic                          move_y;
        logic                          move_z;
        logic        [DELAY_BITS-1:0]  step_delay;
        logic        [1:0]             jog_axis;
        logic                          jog_forward;
        logic        [JOG_CNT_W-1:0]   jog_count;
    } t_in_word;

    typedef struct packed {
        logic                          step_x;
        logic                          step_y;
        logic                          step_z;
        logic                          dir_x;
        logic                          dir_y;
        logic                          dir_z;
        logic                          drivers_enabled;
        logic signed [POS_BITS-1:0]    pos_x;
        logic signed [POS_BITS-1:0]    pos_y;
        logic signed [POS_BITS-1:0]    pos_z;
        logic                          move_done;
        logic        [DELAY_BITS-1:0]  delay_out;
    } t_out_word;

    typedef struct packed {
        logic              load;
        logic              tick;
        logic              clear;
        logic              jog;
        logic              jog_fwd;
        logic [MAG_W-1:0]  total;
    } t_axis_ctl;

    function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_BITS-1:0] res;
        if (v > SUM_POS_MAX) begin
            res = SUM_POS_MAX[POS_BITS-1:0];
        end else if (v < SUM_POS_MIN) begin
            res = SUM_POS_MIN[POS_BITS-1:0];
        end else begin
            res = v[POS_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/tsi_axis.sv =====
module tsi_axis (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tsi_pkg::t_axis_ctl                 i_ctl,
    input  logic signed [tsi_pkg::POS_BITS-1:0] i_target,
    input  logic                               i_move_en,
    input  logic [tsi_pkg::JOG_AMT_W-1:0]      i_jog_amt,
    output logic [tsi_pkg::MAG_W-1:0]          o_mag,
    output logic                               o_step,
    output logic                               o_dir,
    output logic signed [tsi_pkg::POS_BITS-1:0] o_pos
);

    logic signed [tsi_pkg::POS_BITS-1:0] r_pos, n_pos;
    logic [tsi_pkg::MAG_W-1:0]           r_err, n_err;
    logic [tsi_pkg::MAG_W-1:0]           r_mag, n_mag;
    logic                                r_dir, n_dir;

    logic signed [tsi_pkg::MAG_W-1:0]    w_delta;
    logic [tsi_pkg::MAG_W:0]             w_sum;
    logic [tsi_pkg::MAG_W:0]             w_sum_red;
    logic signed [tsi_pkg::SUM_W-1:0]    w_pos_ext;
    logic signed [tsi_pkg::SUM_W-1:0]    w_amt_ext;

    assign w_delta   = i_move_en ? (tsi_pkg::MAG_W'(i_target) - tsi_pkg::MAG_W'(r_pos))
                                 : '0;
    assign o_mag     = w_delta[tsi_pkg::MAG_W-1] ? tsi_pkg::MAG_W'(-w_delta)
                                                 : tsi_pkg::MAG_W'(w_delta);
    assign w_sum     = {1'b0, r_err} + {1'b0, r_mag};
    assign w_sum_red = w_sum - {1'b0, i_ctl.total};
    assign w_pos_ext = tsi_pkg::SUM_W'(r_pos);
    assign w_amt_ext = $signed(tsi_pkg::SUM_W'(i_jog_amt));

    always_comb begin
        n_pos  = r_pos;
        n_err  = r_err;
        n_mag  = r_mag;
        n_dir  = r_dir;
        o_step = 1'b0;
        if (i_ctl.load) begin
            n_mag = o_mag;
            n_err = i_ctl.total >> 1;
            if (o_mag != '0) begin
                n_dir = ~w_delta[tsi_pkg::MAG_W-1];
            end
        end
        if (i_ctl.tick) begin
            if (w_sum >= {1'b0, i_ctl.total}) begin
                n_err  = w_sum_red[tsi_pkg::MAG_W-1:0];
                o_step = 1'b1;
                n_pos  = tsi_pkg::sat_pos(r_dir ? (w_pos_ext + tsi_pkg::SUM_ONE)
                                                : (w_pos_ext - tsi_pkg::SUM_ONE));
            end else begin
                n_err = w_sum[tsi_pkg::MAG_W-1:0];
            end
        end
        if (i_ctl.clear) begin
            n_pos = '0;
        end
        if (i_ctl.jog) begin
            n_dir = i_ctl.jog_fwd;
            n_pos = tsi_pkg::sat_pos(i_ctl.jog_fwd ? (w_pos_ext + w_amt_ext)
                                                   : (w_pos_ext - w_amt_ext));
        end
    end

    assign o_dir = n_dir;
    assign o_pos = n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_err <= '0;
            r_mag <= '0;
            r_dir <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_err <= n_err;
            r_mag <= n_mag;
            r_dir <= n_dir;
        end
    end

endmodule

// ===== design/three_axis_step_interpolator.sv =====
// Channel   Direction  Handshake              Word
// input     in         i_in_valid/o_in_stall  i_in_word  (tsi_pkg::t_in_word)
// output    out        o_out_valid/i_out_stall o_out_word (tsi_pkg::t_out_word)
// config    in         i_cfg_wr_en            i_cfg_wr_data (jog_xy_scale)
//
// Each word passes an input register and a result register, one word per cycle
// while the output side takes results.
// The throughput is set by the combinational Bresenham add and compare per axis.
// Reset is synchronous and active low; the scale register returns to 8.
// A stall on the output holds both stages; a stall on the input is raised only
// while the input register is full and cannot move on.
module three_axis_step_interpolator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tsi_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tsi_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_wr_en,
    input  logic [tsi_pkg::SCALE_W-1:0]    i_cfg_wr_data
);

    tsi_pkg::t_in_word                   r_in;
    logic                                r_in_valid;
    tsi_pkg::t_out_word                  r_out;
    logic                                r_out_valid;

    logic [tsi_pkg::SCALE_W-1:0]         r_scale;
    logic                                r_active, n_active;
    logic [tsi_pkg::MAG_W-1:0]           r_total, n_total;
    logic [tsi_pkg::MAG_W-1:0]           r_steps_left, n_steps_left;
    logic [tsi_pkg::DELAY_BITS-1:0]      r_delay, n_delay;

    logic                                w_adv;
    logic                                w_take;
    logic                                w_load_go;
    logic                                w_start;
    logic                                w_tick_go;
    logic                                w_jog_go;
    logic                                w_done;
    logic [tsi_pkg::MAG_W-1:0]           w_total;
    logic [tsi_pkg::SCALE_W-1:0]         w_scale;
    logic [tsi_pkg::JOG_AMT_W-1:0]       w_jog_amt;

    logic signed [tsi_pkg::POS_BITS-1:0] w_target [tsi_pkg::NUM_AXES];
    logic                                w_move   [tsi_pkg::NUM_AXES];
    logic [tsi_pkg::MAG_W-1:0]           w_mag    [tsi_pkg::NUM_AXES];
    logic                                w_step   [tsi_pkg::NUM_AXES];
    logic                                w_dir    [tsi_pkg::NUM_AXES];
    logic signed [tsi_pkg::POS_BITS-1:0] w_pos    [tsi_pkg::NUM_AXES];
    tsi_pkg::t_axis_ctl                  w_ctl    [tsi_pkg::NUM_AXES];
    tsi_pkg::t_out_word                  n_out;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_take     = i_in_valid && !o_in_stall;

    assign w_target[0] = r_in.target_x;
    assign w_target[1] = r_in.target_y;
    assign w_target[2] = r_in.target_z;
    assign w_move[0]   = r_in.move_x;
    assign w_move[1]   = r_in.move_y;
    assign w_move[2]   = r_in.move_z;

    always_comb begin
        w_total = w_mag[0];
        if (w_mag[1] > w_total) begin
            w_total = w_mag[1];
        end
        if (w_mag[2] > w_total) begin
            w_total = w_mag[2];
        end
    end

    assign w_load_go = w_adv && (r_in.opcode == tsi_pkg::OP_MOVE) && !r_active;
    assign w_start   = w_load_go && (w_total != '0);
    assign w_tick_go = w_adv && (r_in.opcode == tsi_pkg::OP_TICK) && r_active;
    assign w_jog_go  = w_adv && (r_in.opcode == tsi_pkg::OP_JOG) && !r_active;

    assign w_scale   = (r_in.jog_axis == tsi_pkg::AXIS_Z) ? tsi_pkg::SCALE_W'(1) : r_scale;
    assign w_jog_amt = tsi_pkg::JOG_AMT_W'(r_in.jog_count) * tsi_pkg::JOG_AMT_W'(w_scale);

    genvar g;
    generate
        for (g = 0; g < tsi_pkg::NUM_AXES; g++) begin : g_axis
            assign w_ctl[g].load    = w_start;
            assign w_ctl[g].tick    = w_tick_go;
            assign w_ctl[g].clear   = w_adv && (r_in.opcode == tsi_pkg::OP_ZERO);
            assign w_ctl[g].jog     = w_jog_go && (r_in.jog_axis == 2'(g));
            assign w_ctl[g].jog_fwd = r_in.jog_forward;
            assign w_ctl[g].total   = w_start ? w_total : r_total;

            tsi_axis u_axis (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl[g]),
                .i_target  (w_target[g]),
                .i_move_en (w_move[g]),
                .i_jog_amt (w_jog_amt),
                .o_mag     (w_mag[g]),
                .o_step    (w_step[g]),
                .o_dir     (w_dir[g]),
                .o_pos     (w_pos[g])
            );
        end
    endgenerate

    always_comb begin
        n_active     = r_active;
        n_total      = r_total;
        n_steps_left = r_steps_left;
        n_delay      = r_delay;
        w_done       = 1'b0;
        if (w_load_go && (w_total == '0)) begin
            w_done = 1'b1;
        end
        if (w_start) begin
            n_active     = 1'b1;
            n_total      = w_total;
            n_steps_left = w_total;
            n_delay      = r_in.step_delay;
        end
        if (w_tick_go) begin
            if (r_steps_left != '0) begin
                n_steps_left = r_steps_left - 1'b1;
            end
            if (n_steps_left == '0) begin
                n_active = 1'b0;
                w_done   = 1'b1;
            end
        end
        if (w_jog_go) begin
            w_done = 1'b1;
        end
    end

    always_comb begin
        n_out.step_x          = w_step[0];
        n_out.step_y          = w_step[1];
        n_out.step_z          = w_step[2];
        n_out.dir_x           = w_dir[0];
        n_out.dir_y           = w_dir[1];
        n_out.dir_z           = w_dir[2];
        n_out.drivers_enabled = n_active || w_tick_go;
        n_out.pos_x           = w_pos[0];
        n_out.pos_y           = w_pos[1];
        n_out.pos_z           = w_pos[2];
        n_out.move_done       = w_done;
        n_out.delay_out       = w_tick_go ? r_delay : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_scale      <= tsi_pkg::JOG_SCALE_RESET;
            r_active     <= 1'b0;
            r_total      <= '0;
            r_steps_left <= '0;
            r_delay      <= '0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_scale <= i_cfg_wr_data;
            end
            r_active     <= n_active;
            r_total      <= n_total;
            r_steps_left <= n_steps_left;
            r_delay      <= n_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in_word;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_active_has_steps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_steps_left != '0))
        else $error("active move with no steps left");

    a_step_needs_drivers : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.step_x || r_out.step_y || r_out.step_z))
            |-> r_out.drivers_enabled)
        else $error("step pulse without drivers enabled");

    a_last_tick_ends_move : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick_go && (r_steps_left == tsi_pkg::MAG_W'(1))) |=> !r_active)
        else $error("move still active after its last tick");

    a_start_needs_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> (!r_active && !w_tick_go))
        else $error("move started while another is active");
`endif

endmodule
